>>> hw/rtl/hdtu_pkg.sv
// ----------------------------------------------------------------------------
// hdtu_pkg: shared types, constants and functions of the decay trace core
// Holds field widths, the 2^-f table builder and the queue item struct.
// ----------------------------------------------------------------------------
package hdtu_pkg;

  localparam int NUM_TYPES_DEF      = 6;
  localparam int EXP_TABLE_BITS_DEF = 8;
  localparam int TIME_W  = 48;
  localparam int RATE_W  = 24;
  localparam int INV_W   = 32;
  localparam int LEVEL_W = 32;
  localparam int SUM_W   = 48;
  localparam int TYPE_W  = 3;
  localparam int MAX_TYPES = 6;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  localparam logic [1:0] CFG_DECAY_RATE = 2'd0;
  localparam logic [1:0] CFG_INV_RATE   = 2'd1;
  localparam logic [1:0] CFG_WINDOW     = 2'd2;

  // One classified event handed from the front part to the back part.
  typedef struct packed {
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] remain;
    logic [TYPE_W-1:0] etype;
    logic              start;
    logic              err;
  } hdtu_item_t;

  function automatic logic [63:0] hdtu_isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry k of the 2^-(k/2^tb) table in Q1.32, evaluated at elaboration.
  function automatic logic [32:0] hdtu_pow_entry(input int tb, input int k);
    logic [63:0] roots [0:12];
    logic [127:0] acc;
    roots[0] = 64'd1 << 31;
    for (int i = 1; i <= 12; i++) roots[i] = hdtu_isqrt(roots[i-1] << 32);
    if (k >= (1 << tb)) return 33'd1 << 31;
    acc = 128'd1 << 32;
    for (int j = 0; j < tb; j++) begin
      if (((k >> (tb - 1 - j)) & 1) != 0)
        acc = (acc * roots[j+1] + (128'd1 << 31)) >> 32;
    end
    return acc[32:0];
  endfunction

endpackage

>>> hw/rtl/hdtu_exp.sv
// ----------------------------------------------------------------------------
// hdtu_exp: pipelined exp(-beta*span) in Q1.32
// Four register stages: product, log2 scale, table lookup, interpolation.
// ----------------------------------------------------------------------------
module hdtu_exp #(
  parameter int EXP_TABLE_BITS = hdtu_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        go,
  input  logic [hdtu_pkg::RATE_W-1:0] rate,
  input  logic [hdtu_pkg::TIME_W-1:0] span,
  output logic [32:0]                 factor
);
  localparam int TAB_N = (1 << EXP_TABLE_BITS) + 1;
  localparam int SH    = 24 - EXP_TABLE_BITS;

  logic [32:0] pow_tab [0:TAB_N-1];
  always_comb begin
    for (int k = 0; k < TAB_N; k++) pow_tab[k] = hdtu_pkg::hdtu_pow_entry(EXP_TABLE_BITS, k);
  end

  // Stage 1: a = rate*hi + (rate*lo >> 24).
  logic [47:0] prod_hi;
  logic [47:0] prod_lo;
  always_ff @(posedge clk) begin
    if (go) begin
      prod_hi <= 48'(rate) * 48'(span[47:24]);
      prod_lo <= 48'(rate) * 48'(span[23:0]);
    end
  end
  logic [48:0] a_val;
  assign a_val = 49'(prod_hi) + 49'(prod_lo[47:24]);

  // Stage 2: y = a*log2(e); a below 32.0 fits in 29 bits.
  logic        big2;
  logic [59:0] y_prod;
  always_ff @(posedge clk) begin
    big2   <= (a_val >= (49'd32 << 24));
    y_prod <= 60'(a_val[28:0]) * 60'(hdtu_pkg::LOG2E_Q30);
  end
  logic [29:0] y_val;
  assign y_val = y_prod[59:30];

  // Stage 3: table lookup.
  logic        zero3;
  logic [4:0]  n3;
  logic [SH-1:0] rem3;
  logic [32:0] t0;
  logic [32:0] t1;
  logic [EXP_TABLE_BITS:0] idx;
  assign idx = {1'b0, y_val[23:SH]};
  always_ff @(posedge clk) begin
    zero3 <= big2 || (y_val[29:24] >= 6'd32);
    n3    <= y_val[28:24];
    rem3  <= y_val[SH-1:0];
    t0    <= pow_tab[idx];
    t1    <= pow_tab[idx + 1'b1];
  end

  // Stage 4: interpolation and shift.
  logic [32+SH:0] dprod;
  logic [32:0]    interp;
  assign dprod  = (33+SH)'(t0 - t1) * (33+SH)'(rem3);
  assign interp = t0 - 33'(dprod >> SH);
  always_ff @(posedge clk) begin
    factor <= zero3 ? 33'd0 : (interp >> n3);
  end
endmodule

>>> hw/rtl/hdtu_front.sv
// ----------------------------------------------------------------------------
// hdtu_front: accepts events, tracks previous time, forms dt and T - t
// Writes one classified item per accepted event into a small queue.
// ----------------------------------------------------------------------------
module hdtu_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hdtu_pkg::TIME_W-1:0] event_time,
  input  logic [hdtu_pkg::TYPE_W-1:0] event_class,
  input  logic                        start_of_stream,
  input  logic [hdtu_pkg::TIME_W-1:0] window_length,
  input  logic                        q_full,
  output logic                        q_push,
  output hdtu_pkg::hdtu_item_t        q_item
);
  logic [hdtu_pkg::TIME_W-1:0] previous_time;
  logic [hdtu_pkg::TIME_W-1:0] base;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign base     = start_of_stream ? '0 : previous_time;

  always_comb begin
    q_item.etype  = event_class;
    q_item.start  = start_of_stream;
    q_item.err    = (event_time < base);
    q_item.dt     = q_item.err ? '0 : event_time - base;
    q_item.remain = (window_length > event_time) ? window_length - event_time : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time <= '0;
    end else if (q_push) begin
      previous_time <= q_item.err ? base : event_time;
    end
  end
endmodule

>>> hw/rtl/hdtu_back.sv
// ----------------------------------------------------------------------------
// hdtu_back: decays the levels, updates one sum and presents the result
// A small sequencer drives the shared exponential pipeline twice per item.
// ----------------------------------------------------------------------------
module hdtu_back #(
  parameter int NUM_TYPES      = hdtu_pkg::NUM_TYPES_DEF,
  parameter int EXP_TABLE_BITS = hdtu_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  hdtu_pkg::hdtu_item_t        q_item,
  output logic                        q_pop,
  input  logic [hdtu_pkg::RATE_W-1:0] decay_rate,
  input  logic [hdtu_pkg::INV_W-1:0]  inverse_decay_rate,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hdtu_pkg::TYPE_W-1:0] type_out,
  output logic [hdtu_pkg::LEVEL_W-1:0] levels_out [hdtu_pkg::MAX_TYPES],
  output logic [hdtu_pkg::SUM_W-1:0]  compensator_sum,
  output logic                        order_error
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_DECAY = 3'd2;
  localparam logic [2:0] ST_TERM  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam int EXP_LAT = 4;

  logic [2:0] state;
  logic [2:0] count;
  hdtu_pkg::hdtu_item_t cur;
  logic [hdtu_pkg::LEVEL_W-1:0] lvl [NUM_TYPES];
  logic [hdtu_pkg::SUM_W-1:0]   sums [NUM_TYPES];
  logic [32:0] f_dt;
  logic [32:0] factor;
  logic        go;
  logic [hdtu_pkg::TIME_W-1:0] span;
  logic [64:0] term_prod;
  logic        type_ok;
  logic [$clog2(NUM_TYPES)-1:0] tidx;
  logic [49:0] sum_wide;
  logic [hdtu_pkg::SUM_W-1:0]   sum_sat;

  assign type_ok = (32'(cur.etype) < NUM_TYPES);
  assign tidx    = cur.etype[$clog2(NUM_TYPES)-1:0];
  assign q_pop   = (state == ST_IDLE) && !out_valid && q_valid;
  assign go      = 1'b1;
  assign span    = (count == 3'd0) ? cur.dt : cur.remain;

  // Sum of the event's class plus the new term, clamped to the field.
  assign sum_wide = 50'(sums[tidx]) + 50'(term_prod[64:24]);
  assign sum_sat  = (sum_wide > 50'(48'hFFFFFFFFFFFF)) ? '1 : sum_wide[47:0];

  hdtu_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
    .clk(clk), .go(go), .rate(decay_rate), .span(span), .factor(factor)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < NUM_TYPES; j++) begin
        lvl[j]  <= '0;
        sums[j] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            cur   <= q_item;
            count <= '0;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // Slot 0 feeds dt, slot 1 feeds T - t; wait for the dt factor to drain.
          count <= count + 3'd1;
          if (count == 3'(EXP_LAT - 1)) state <= ST_DECAY;
        end
        ST_DECAY: begin
          f_dt <= factor;
          state <= ST_TERM;
        end
        ST_TERM: begin
          for (int j = 0; j < NUM_TYPES; j++) begin
            lvl[j] <= cur.start ? '0 :
              32'((64'(lvl[j]) * 64'(f_dt)) >> 32);
          end
          term_prod <= 65'(33'(34'h100000000 - 34'(factor))) * 65'(inverse_decay_rate);
          if (cur.start) begin
            for (int j = 0; j < NUM_TYPES; j++) sums[j] <= '0;
          end
          state <= ST_SUM;
        end
        ST_SUM: begin
          type_out    <= cur.etype;
          order_error <= cur.err;
          for (int j = 0; j < hdtu_pkg::MAX_TYPES; j++)
            levels_out[j] <= (j < NUM_TYPES) ? lvl[j] : '0;
          compensator_sum <= type_ok ? sum_sat : '0;
          if (type_ok) begin
            sums[tidx] <= sum_sat;
            lvl[tidx] <= (lvl[tidx] > 32'hFFFEFFFF) ? 32'hFFFFFFFF : lvl[tidx] + 32'h10000;
          end
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/hdtu_queue.sv
// ----------------------------------------------------------------------------
// hdtu_queue: two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module hdtu_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  hdtu_pkg::hdtu_item_t din,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output hdtu_pkg::hdtu_item_t dout
);
  hdtu_pkg::hdtu_item_t mem [2];
  logic wptr;
  logic rptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> hw/rtl/hawkes_decay_trace_update_core.sv
// ----------------------------------------------------------------------------
// hawkes_decay_trace_update_core: Hawkes exponential kernel recursion
// Decays six excitation levels per event and updates compensator sums.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: event_time[47:0]; tuser: event_class[2:0], start[3]
// m_axis    out        tdata: 6 levels, compensator_sum, order_error
// cfg       in         index selects decay rate, inverse rate, window length
//
// A result passes, after its input transaction, through the queue, the shared
// exponential pipeline (fed dt, then T - t on the next cycle), a state that
// latches the dt factor, one that decays the levels and forms the compensator
// term, and one that updates the sum. The back part takes the next event only
// in the cycle after the result transaction, so it works on one event at a
// time. The front part takes events while a two-entry queue has room, so
// input and output stall independently. Reset is synchronous and clears the
// levels, sums and previous time.
module hawkes_decay_trace_update_core #(
  parameter int NUM_TYPES      = hdtu_pkg::NUM_TYPES_DEF,
  parameter int EXP_TABLE_BITS = hdtu_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // event_time[47:0]
  input  logic [3:0]   s_axis_tuser,   // event_class[2:0], start_of_stream[3]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // level_zero[31:0] .. level_five[191:160], compensator_sum[239:192],
  // order_error[240], zero fill to 248
  output logic [247:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // type_out[2:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);
  logic [hdtu_pkg::RATE_W-1:0] decay_rate;
  logic [hdtu_pkg::INV_W-1:0]  inverse_decay_rate;
  logic [hdtu_pkg::TIME_W-1:0] window_length;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate         <= 24'd655360;
      inverse_decay_rate <= 32'd6554;
      window_length      <= 48'd100502234726400;
    end else if (cfg_valid) begin
      case (cfg_index)
        hdtu_pkg::CFG_DECAY_RATE: decay_rate         <= cfg_data[23:0];
        hdtu_pkg::CFG_INV_RATE:   inverse_decay_rate <= cfg_data[31:0];
        hdtu_pkg::CFG_WINDOW:     window_length      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  hdtu_pkg::hdtu_item_t q_in;
  hdtu_pkg::hdtu_item_t q_out;

  hdtu_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .event_time(s_axis_tdata), .event_class(s_axis_tuser[2:0]),
    .start_of_stream(s_axis_tuser[3]), .window_length(window_length),
    .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  hdtu_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .valid(q_valid), .dout(q_out)
  );

  logic [hdtu_pkg::LEVEL_W-1:0] levels [hdtu_pkg::MAX_TYPES];
  logic [hdtu_pkg::SUM_W-1:0]   compensator_sum;
  logic                         order_error;

  hdtu_back #(.NUM_TYPES(NUM_TYPES), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_out), .q_pop(q_pop),
    .decay_rate(decay_rate), .inverse_decay_rate(inverse_decay_rate),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .type_out(m_axis_tuser), .levels_out(levels),
    .compensator_sum(compensator_sum), .order_error(order_error)
  );

  assign m_axis_tdata = {7'd0, order_error, compensator_sum, levels[5], levels[4],
                         levels[3], levels[2], levels[1], levels[0]};
endmodule
